// ===== rtl/rdsrt_pkg.sv =====
package rdsrt_pkg;

   localparam int TextLength = 64;
   localparam int ChunkCount = TextLength / 8;
   localparam int RowBits    = $clog2(ChunkCount);
   localparam int PosBits    = $clog2(TextLength);

   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_MAX   = 8'h7D;

   localparam logic [4:0] GROUP_2A = 5'h04;
   localparam logic [4:0] GROUP_2B = 5'h05;

   typedef struct packed {
      logic       command;
      logic [7:0] block_b_high;
      logic [7:0] block_b_low;
      logic [7:0] block_c_high;
      logic [7:0] block_c_low;
      logic [7:0] block_d_high;
      logic [7:0] block_d_low;
      logic [7:0] fifo_level;
   } req_type;

   typedef struct packed {
      logic        shown_updated;
      logic [2:0]  chunk_index;
      logic [63:0] text_chunk;
      logic        last_of_run;
      logic [7:0]  queue_remaining;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_EV,
      ST_CHAR_RD,
      ST_CHAR_WR,
      ST_COPY_RD,
      ST_COPY_WR,
      ST_EMIT_RD,
      ST_EMIT_LD
   } state_type;

   // first byte in a row that is either zero or CR
   typedef struct packed {
      logic       hit;
      logic       is_cr;
      logic [2:0] idx;
   } scan_type;

   function automatic logic [7:0] sanitize(input logic [7:0] c);
      logic [7:0] r;
      r = (c == CH_VT) ? CH_LF : c;
      if ((r < CH_SPACE || r > CH_MAX) && r != CH_LF && r != CH_CR) begin
         r = CH_SPACE;
      end
      return r;
   endfunction

   function automatic scan_type scan_row(input logic [63:0] row);
      scan_type s;
      s = '0;
      for (int b = 0; b < 8; b++) begin
         if (!s.hit && (row[8*b +: 8] == 8'h00 || row[8*b +: 8] == CH_CR)) begin
            s.hit   = 1'b1;
            s.is_cr = (row[8*b +: 8] == CH_CR);
            s.idx   = 3'(b);
         end
      end
      return s;
   endfunction

endpackage

// ===== rtl/rds_radiotext_assembler.sv =====
// RDS RadioText assembler for group types 2A and 2B.
// req_ channel: one word per RDS group (blocks B, C, D as bytes) or, with
// command set, a station change that clears both text stores.
// rsp_ channel: one word with shown_updated low when the shown text is
// unchanged, else eight words carrying the shown text in 64-bit chunks,
// chunk_index 0 to 7, last_of_run on the final word of each input.
// One word is in work at a time; req_ready is high only when idle.
// Steps per word, all paced by the single read port of each text store:
//   station change: the eight result words; other group type: one result word
//   2A/2B group: a CR scan (row by row up to the first zero or CR,
//   skipped on an A/B switch), then each character in turn, a rescan
//   (only when not yet terminated), a row copy (when newly terminated)
//   and finally the result words.
// The last result sits in the output register while the next word is
// taken; a stalled rsp_ready holds the sequencer in its emit step.
// After reset both stores read as empty through per-character valid bits,
// so no clearing pass is needed and the block is ready at once.
module rds_radiotext_assembler (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  rdsrt_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rdsrt_pkg::rsp_type  rsp_data
);
   import rdsrt_pkg::*;

   localparam logic [RowBits-1:0] LastRow = RowBits'(ChunkCount - 1);

   state_type state_ff, state_in;
   req_type   req_ff;

   logic [RowBits-1:0]    row_ff, row_in;
   logic [1:0]            char_ff, char_in;
   logic                  phase_ff, phase_in;
   logic                  term_ff, term_in;
   logic                  changed_ff, changed_in;
   logic                  ab_ff, ab_in;
   logic [PosBits-1:0]    len_ff, len_in;
   logic [TextLength-1:0] pend_vld_ff, pend_vld_in;
   logic [TextLength-1:0] shown_vld_ff, shown_vld_in;

   logic [63:0] pend_mem  [ChunkCount];
   logic [63:0] shown_mem [ChunkCount];
   logic [63:0] pend_rd_ff, shown_rd_ff;
   logic [7:0]  pend_rv_ff, shown_rv_ff;

   rsp_type rsp_ff, rsp_in;
   logic    rsp_vld_ff, rsp_vld_in;

   logic               accept, rsp_free;
   logic [4:0]         gtype_new, gtype;
   logic               grp_new, is_2a;
   logic [PosBits-1:0] char_pos;
   logic [7:0]         raw_char, clean_char, pend_char, shown_char;
   logic [RowBits-1:0] rd_row;
   logic [63:0]        pend_row, shown_row, copy_row;
   scan_type           scan;
   logic               scan_end, scan_term, last_char, commit, char_live;
   logic               pend_we, shown_we, copy_we;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_free  = !rsp_vld_ff || rsp_ready;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   assign gtype_new = req_data.block_b_high[7:3];
   assign grp_new   = (gtype_new == GROUP_2A) || (gtype_new == GROUP_2B);
   assign gtype     = req_ff.block_b_high[7:3];
   assign is_2a     = (gtype == GROUP_2A);

   always_comb begin
      if (is_2a) begin
         char_pos = {req_ff.block_b_low[3:0], char_ff};
         unique case (char_ff)
            2'd0:    raw_char = req_ff.block_c_high;
            2'd1:    raw_char = req_ff.block_c_low;
            2'd2:    raw_char = req_ff.block_d_high;
            default: raw_char = req_ff.block_d_low;
         endcase
      end else begin
         char_pos = {1'b0, req_ff.block_b_low[3:0], char_ff[0]};
         raw_char = char_ff[0] ? req_ff.block_d_low : req_ff.block_d_high;
      end
   end

   assign last_char = is_2a ? (char_ff == 2'd3) : (char_ff == 2'd1);
   assign rd_row    = (state_ff == ST_CHAR_RD || state_ff == ST_CHAR_WR)
                      ? char_pos[PosBits-1:3] : row_ff;

   // bytes never written read as zero
   always_comb begin
      for (int b = 0; b < 8; b++) begin
         pend_row[8*b +: 8]  = pend_rv_ff[b]  ? pend_rd_ff[8*b +: 8]  : 8'h00;
         shown_row[8*b +: 8] = shown_rv_ff[b] ? shown_rd_ff[8*b +: 8] : 8'h00;
         copy_row[8*b +: 8]  = ({row_ff, 3'(b)} < len_ff) ? pend_row[8*b +: 8] : 8'h00;
      end
   end

   assign scan       = scan_row(pend_row);
   assign scan_end   = scan.hit || (row_ff == LastRow);
   assign scan_term  = scan.hit && scan.is_cr;
   assign clean_char = sanitize(raw_char);
   assign pend_char  = pend_row[{char_pos[2:0], 3'b000} +: 8];
   assign shown_char = shown_row[{char_pos[2:0], 3'b000} +: 8];
   assign char_live  = (raw_char != 8'h00);
   assign commit     = term_ff && (pend_char == clean_char) && (shown_char != clean_char)
                       && (clean_char != CH_CR);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.command || !grp_new) begin
                  state_in = ST_EMIT_RD;
               end else if (req_data.block_b_low[4] != ab_ff) begin
                  state_in = ST_CHAR_RD;
               end else begin
                  state_in = ST_SCAN_RD;
               end
            end
         end
         ST_SCAN_RD: state_in = ST_SCAN_EV;
         ST_SCAN_EV: begin
            if (!scan_end) begin
               state_in = ST_SCAN_RD;
            end else if (!phase_ff) begin
               state_in = ST_CHAR_RD;
            end else begin
               state_in = scan_term ? ST_COPY_RD : ST_EMIT_RD;
            end
         end
         ST_CHAR_RD: state_in = ST_CHAR_WR;
         ST_CHAR_WR: begin
            if (last_char) begin
               state_in = term_ff ? ST_EMIT_RD : ST_SCAN_RD;
            end else begin
               state_in = ST_CHAR_RD;
            end
         end
         ST_COPY_RD: state_in = ST_COPY_WR;
         ST_COPY_WR: state_in = (row_ff == LastRow) ? ST_EMIT_RD : ST_COPY_RD;
         ST_EMIT_RD: state_in = ST_EMIT_LD;
         ST_EMIT_LD: begin
            if (rsp_free) begin
               state_in = (!changed_ff || row_ff == LastRow) ? ST_IDLE : ST_EMIT_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath control
   always_comb begin
      row_in       = row_ff;
      char_in      = char_ff;
      phase_in     = phase_ff;
      term_in      = term_ff;
      changed_in   = changed_ff;
      ab_in        = ab_ff;
      len_in       = len_ff;
      pend_vld_in  = pend_vld_ff;
      shown_vld_in = shown_vld_ff;
      pend_we      = 1'b0;
      shown_we     = 1'b0;
      copy_we      = 1'b0;
      rsp_in       = rsp_ff;
      rsp_vld_in   = rsp_vld_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               row_in     = '0;
               char_in    = '0;
               phase_in   = 1'b0;
               changed_in = req_data.command;
               if (req_data.command) begin
                  pend_vld_in  = '0;
                  shown_vld_in = '0;
               end else if (grp_new && req_data.block_b_low[4] != ab_ff) begin
                  // A/B switch: fresh text, treated as unterminated
                  pend_vld_in = '0;
                  ab_in       = req_data.block_b_low[4];
                  term_in     = 1'b0;
               end
            end
         end
         ST_SCAN_EV: begin
            if (!scan_end) begin
               row_in = RowBits'(row_ff + 1'b1);
            end else begin
               row_in = '0;
               if (!phase_ff) begin
                  term_in = scan_term;
               end else if (scan_term) begin
                  len_in     = {row_ff, scan.idx};
                  changed_in = 1'b1;
               end
            end
         end
         ST_CHAR_WR: begin
            if (char_live) begin
               if (commit) begin
                  shown_we               = 1'b1;
                  shown_vld_in[char_pos] = 1'b1;
                  changed_in             = 1'b1;
               end else begin
                  pend_we               = 1'b1;
                  pend_vld_in[char_pos] = 1'b1;
               end
            end
            char_in = 2'(char_ff + 1'b1);
            if (last_char) begin
               phase_in = 1'b1;
               row_in   = '0;
            end
         end
         ST_COPY_WR: begin
            copy_we                                 = 1'b1;
            shown_vld_in[{row_ff, 3'b000} +: 8]     = 8'hFF;
            row_in                                  = RowBits'(row_ff + 1'b1);
         end
         ST_EMIT_LD: begin
            if (rsp_free) begin
               rsp_vld_in             = 1'b1;
               rsp_in.shown_updated   = changed_ff;
               rsp_in.chunk_index     = changed_ff ? row_ff : '0;
               rsp_in.text_chunk      = changed_ff ? shown_row : '0;
               rsp_in.last_of_run     = !changed_ff || (row_ff == LastRow);
               rsp_in.queue_remaining = req_ff.fifo_level;
               row_in                 = RowBits'(row_ff + 1'b1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_ff       <= '0;
         char_ff      <= '0;
         phase_ff     <= 1'b0;
         term_ff      <= 1'b0;
         changed_ff   <= 1'b0;
         ab_ff        <= 1'b0;
         pend_vld_ff  <= '0;
         shown_vld_ff <= '0;
         rsp_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         char_ff      <= char_in;
         phase_ff     <= phase_in;
         term_ff      <= term_in;
         changed_ff   <= changed_in;
         ab_ff        <= ab_in;
         pend_vld_ff  <= pend_vld_in;
         shown_vld_ff <= shown_vld_in;
         rsp_vld_ff   <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      len_ff <= len_in;
      rsp_ff <= rsp_in;
   end

   // text stores: one row-wide read port each, byte or row writes
   always_ff @(posedge clock) begin
      if (pend_we) begin
         pend_mem[char_pos[PosBits-1:3]][{char_pos[2:0], 3'b000} +: 8] <= clean_char;
      end
      if (shown_we) begin
         shown_mem[char_pos[PosBits-1:3]][{char_pos[2:0], 3'b000} +: 8] <= clean_char;
      end
      if (copy_we) begin
         shown_mem[row_ff] <= copy_row;
      end
      pend_rd_ff  <= pend_mem[rd_row];
      shown_rd_ff <= shown_mem[rd_row];
      pend_rv_ff  <= pend_vld_in[{rd_row, 3'b000} +: 8] & pend_vld_ff[{rd_row, 3'b000} +: 8];
      shown_rv_ff <= shown_vld_ff[{rd_row, 3'b000} +: 8];
   end

   a_last_is_chunk7: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_ff.shown_updated && rsp_ff.last_of_run |-> rsp_ff.chunk_index == 3'd7)
      else $error("changed run ended before chunk 7");

   a_quiet_word: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && !rsp_ff.shown_updated |->
         rsp_ff.last_of_run && rsp_ff.text_chunk == 64'd0 && rsp_ff.chunk_index == 3'd0)
      else $error("unchanged word carries text");

   a_station_clear: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.command |=> pend_vld_ff == '0 && shown_vld_ff == '0 && changed_ff)
      else $error("station change did not clear stores");

   a_copy_only_new: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_COPY_WR |-> !term_ff && changed_ff && phase_ff)
      else $error("copy of an already terminated text");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && !rsp_ready |=> rsp_vld_ff)
      else $error("unaccepted result word dropped");

endmodule
